### src/gim_pkg.sv
`timescale 1ns / 1ps
// gim_pkg: shared constants, state encoding and scan control type for the
// grey image median block; no dependencies

package gim_pkg;

    localparam int LEVEL_W    = 8;
    localparam int HIST_DEPTH = 1 << LEVEL_W;
    localparam int COUNT_W    = 21;
    localparam int ADDR_CNT_W = LEVEL_W + 1;

    localparam logic [COUNT_W-1:0] MAX_PIXELS = COUNT_W'(1048576);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = {LEVEL_W{1'b1}};

    // one-hot control states
    typedef enum logic [2:0] {
        ST_INIT = 3'b001,
        ST_RUN  = 3'b010,
        ST_SCAN = 3'b100
    } t_state;

    // one bin check of the cumulative scan
    typedef struct packed {
        logic               chk;
        logic               first;
        logic [LEVEL_W-1:0] addr;
    } t_scan_ctl;

endpackage

### src/grey_image_median.sv
`timescale 1ns / 1ps
// grey_image_median: one pixel per cycle into a 256-bin histogram; on the last pixel the
// upper median is found by a cumulative bin scan that also clears the bins.
// throughput: one pixel per cycle while busy is low; busy stays high after the
// last pixel beat while the 256 bins are read, summed and cleared, one bin per memory read.
// o_done pulses for one cycle once the last bin check of the scan finishes.
// reset: synchronous active low; a clearing pass over all 256 bins follows reset with busy high.
// depends on gim_pkg, gim_hist_ram, gim_median_scan

module grey_image_median
    import gim_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [LEVEL_W-1:0] i_grey_level,
    input  logic               i_last_pixel,
    output logic               o_done,
    output logic [LEVEL_W-1:0] o_median_level,
    output logic               o_count_overflow
);

    // control state
    t_state                r_state;
    logic [ADDR_CNT_W-1:0] r_addr;      // clear / scan read counter
    logic [COUNT_W-1:0]    r_total;     // pixels counted this frame
    logic                  r_ovf;       // a pixel was dropped this frame

    // increment stage: read issued at the beat, write in the following cycle
    logic                  r_upd_valid;
    logic [LEVEL_W-1:0]    r_upd_level;

    // last written bin, covers a read issued at the edge of that write
    logic                  r_fwd_valid;
    logic [LEVEL_W-1:0]    r_fwd_level;
    logic [COUNT_W-1:0]    r_fwd_data;

    // scan check stage, one bin per cycle
    logic                  r_chk_valid;
    logic [LEVEL_W-1:0]    r_chk_addr;

    // result registers
    logic                  r_done;
    logic [LEVEL_W-1:0]    r_median;
    logic                  r_ovf_out;

    logic                  accept;
    logic                  count_ok;
    logic                  scan_issue;
    logic                  scan_end;
    logic                  init_end;

    logic                  mem_wr_en;
    logic [LEVEL_W-1:0]    mem_wr_addr;
    logic [COUNT_W-1:0]    mem_wr_data;
    logic                  mem_rd_en;
    logic [LEVEL_W-1:0]    mem_rd_addr;
    logic [COUNT_W-1:0]    mem_rd_data;

    logic [COUNT_W-1:0]    upd_bin;
    logic [COUNT_W-1:0]    upd_new;
    logic [COUNT_W-1:0]    scan_bin;
    t_scan_ctl             scan_ctl;
    logic [LEVEL_W-1:0]    scan_median;

    assign busy       = (r_state != ST_RUN);
    assign accept     = start && !busy;
    assign count_ok   = (r_total < MAX_PIXELS);
    assign scan_issue = (r_state == ST_SCAN) && !r_addr[ADDR_CNT_W-1];
    assign scan_end   = r_chk_valid && (r_chk_addr == LEVEL_MAX);
    assign init_end   = (r_state == ST_INIT) && (r_addr[LEVEL_W-1:0] == LEVEL_MAX);

    // bin values seen through the forwarding register
    always_comb begin
        upd_bin  = (r_fwd_valid && (r_fwd_level == r_upd_level)) ? r_fwd_data : mem_rd_data;
        upd_new  = upd_bin + COUNT_W'(1);
        scan_bin = (r_fwd_valid && (r_fwd_level == r_chk_addr)) ? r_fwd_data : mem_rd_data;
    end

    // memory port selection; pixel increments and scan clears never coincide
    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = i_grey_level;
        if (accept) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = i_grey_level;
        end else if (scan_issue) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = r_addr[LEVEL_W-1:0];
        end

        mem_wr_en   = 1'b0;
        mem_wr_addr = r_upd_level;
        mem_wr_data = upd_new;
        if (r_upd_valid) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = r_upd_level;
            mem_wr_data = upd_new;
        end else if (r_chk_valid) begin
            // scan clears each bin right after reading it
            mem_wr_en   = 1'b1;
            mem_wr_addr = r_chk_addr;
            mem_wr_data = '0;
        end else if (r_state == ST_INIT) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = r_addr[LEVEL_W-1:0];
            mem_wr_data = '0;
        end
    end

    gim_hist_ram u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    always_comb begin
        scan_ctl.chk   = r_chk_valid;
        scan_ctl.first = (r_chk_addr == '0);
        scan_ctl.addr  = r_chk_addr;
    end

    // target index is total/2; total is final once the scan runs
    gim_median_scan u_median_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (scan_ctl),
        .i_bin    (scan_bin),
        .i_target (r_total >> 1),
        .o_median (scan_median)
    );

    // control state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_addr      <= '0;
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_upd_valid <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_chk_valid <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            // result beat goes out as the last bin check finishes
            r_done      <= scan_end;
            r_upd_valid <= accept && count_ok;
            r_fwd_valid <= r_upd_valid;
            r_chk_valid <= scan_issue;
            case (r_state)
                ST_INIT: begin
                    if (init_end) begin
                        r_state <= ST_RUN;
                        r_addr  <= '0;
                    end else begin
                        r_addr <= r_addr + ADDR_CNT_W'(1);
                    end
                end
                ST_RUN: begin
                    if (accept) begin
                        // saturate: beats past the limit are dropped and flagged
                        if (count_ok) begin
                            r_total <= r_total + COUNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_pixel) begin
                            r_state <= ST_SCAN;
                            r_addr  <= '0;
                        end
                    end
                end
                ST_SCAN: begin
                    if (scan_end) begin
                        r_state <= ST_RUN;
                        r_addr  <= '0;
                        r_total <= '0;
                        r_ovf   <= 1'b0;
                    end else if (scan_issue) begin
                        r_addr <= r_addr + ADDR_CNT_W'(1);
                    end
                end
                default: begin
                    r_state <= ST_INIT;
                    r_addr  <= '0;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_upd_level <= i_grey_level;
        end
        if (r_upd_valid) begin
            r_fwd_level <= r_upd_level;
            r_fwd_data  <= upd_new;
        end
        if (scan_issue) begin
            r_chk_addr <= r_addr[LEVEL_W-1:0];
        end
        if (scan_end) begin
            r_median  <= scan_median;
            r_ovf_out <= r_ovf;
        end
    end

    assign o_done           = r_done;
    assign o_median_level   = r_median;
    assign o_count_overflow = r_ovf_out;

    // the result beat always comes with the block ready again
    a_done_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

    // frame count never passes the saturation limit
    a_total_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= MAX_PIXELS)
        else $error("pixel total above limit");

    // last pixel beat starts the scan
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_pixel) |=> (busy && (r_state == ST_SCAN)))
        else $error("last pixel did not start scan");

    // increment writes and scan clears never share the write port
    a_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_upd_valid && r_chk_valid))
        else $error("write port conflict");

endmodule

### src/gim_hist_ram.sv
`timescale 1ns / 1ps
// gim_hist_ram: 256 x 21 histogram memory, one write and one read port,
// registered read data; depends on gim_pkg

module gim_hist_ram
    import gim_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [LEVEL_W-1:0] i_wr_addr,
    input  logic [COUNT_W-1:0] i_wr_data,
    input  logic               i_rd_en,
    input  logic [LEVEL_W-1:0] i_rd_addr,
    output logic [COUNT_W-1:0] o_rd_data
);

    logic [COUNT_W-1:0] r_mem [HIST_DEPTH];
    logic [COUNT_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read before write on the same address
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/gim_median_scan.sv
`timescale 1ns / 1ps
// gim_median_scan: running cumulative bin sum and first-crossing search
// over one bin per cycle; depends on gim_pkg

module gim_median_scan
    import gim_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_scan_ctl          i_ctl,
    input  logic [COUNT_W-1:0] i_bin,
    input  logic [COUNT_W-1:0] i_target,
    output logic [LEVEL_W-1:0] o_median
);

    logic [COUNT_W-1:0] r_running;
    logic               r_found;
    logic [LEVEL_W-1:0] r_median;

    logic [COUNT_W-1:0] run_prev;
    logic               found_prev;
    logic [COUNT_W-1:0] n_running;
    logic               hit;
    logic [LEVEL_W-1:0] n_median;

    always_comb begin
        run_prev   = i_ctl.first ? '0 : r_running;
        found_prev = i_ctl.first ? 1'b0 : r_found;
        n_running  = run_prev + i_bin;
        hit        = !found_prev && (n_running > i_target);
        if (hit) begin
            n_median = i_ctl.addr;
        end else if (found_prev) begin
            n_median = r_median;
        end else begin
            n_median = LEVEL_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.chk) begin
            r_found <= found_prev || hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.chk) begin
            r_running <= n_running;
            r_median  <= n_median;
        end
    end

    assign o_median = n_median;

endmodule

### sim/grey_image_median_test.sv
`timescale 1ns / 1ps
// grey_image_median_test: self-checking bench for the grey image median block; drives pixel
// frames through the start/busy handshake and checks every done pulse against a histogram
// predictor kept in a small scoreboard class. depends on gim_pkg and grey_image_median

module grey_image_median_test
    import gim_pkg::*;
();

    localparam int CLK_HALF    = 6;
    localparam int RESET_CYC   = 7;
    localparam int PIXEL_GOAL  = 1400;
    // drain margin covers the scan after the last beat and the clearing pass after reset
    localparam int DRAIN_CYC   = 300;
    localparam int STALL_LIMIT = 2000;

    // how the levels of a random frame are chosen
    typedef enum int {
        MIX_UNIFORM,
        MIX_CLUSTER,
        MIX_FLAT,
        MIX_EXTREMES
    } t_level_mix;

    typedef struct packed {
        logic [LEVEL_W-1:0] median_level;
        logic               count_overflow;
    } t_median_res;

    // histogram predictor and store of pending median results
    class median_board;
        int unsigned level_count [HIST_DEPTH];
        int unsigned pixel_total;
        bit          overflow_seen;
        t_median_res pending_q [$];
        int unsigned failures;

        function void note_pixel(logic [LEVEL_W-1:0] level, logic last_pixel);
            t_median_res res;
            int unsigned target;
            int unsigned running;
            bit          found;
            // saturated frames drop further pixels, the last one too
            if (pixel_total < MAX_PIXELS) begin
                level_count[level]++;
                pixel_total++;
            end else begin
                overflow_seen = 1'b1;
            end
            if (last_pixel) begin
                target             = pixel_total / 2;
                running            = 0;
                found              = 1'b0;
                res.median_level   = LEVEL_MAX;
                res.count_overflow = overflow_seen;
                for (int lv = 0; lv < HIST_DEPTH; lv++) begin
                    running += level_count[lv];
                    if (!found && running > target) begin
                        res.median_level = LEVEL_W'(lv);
                        found            = 1'b1;
                    end
                end
                pending_q = {pending_q, res};
                foreach (level_count[i]) level_count[i] = 0;
                pixel_total   = 0;
                overflow_seen = 1'b0;
            end
        endfunction

        function void check_result(logic [LEVEL_W-1:0] median_level, logic count_overflow);
            t_median_res want;
            if (pending_q.size() == 0) begin
                $error("result with no frame pending: median_level %0d, count_overflow %0b",
                       median_level, count_overflow);
                failures++;
                return;
            end
            want = pending_q.pop_front();
            if (median_level !== want.median_level) begin
                $error("median_level: expected %0d, got %0d", want.median_level, median_level);
                failures++;
            end
            if (count_overflow !== want.count_overflow) begin
                $error("count_overflow: expected %0b, got %0b",
                       want.count_overflow, count_overflow);
                failures++;
            end
        endfunction
    endclass

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               start            = 1'b0;
    logic               busy;
    logic [LEVEL_W-1:0] i_grey_level     = '0;
    logic               i_last_pixel     = 1'b0;
    logic               o_done;
    logic [LEVEL_W-1:0] o_median_level;
    logic               o_count_overflow;

    median_board board = new;
    int unsigned pixels_sent  = 0;
    int unsigned burst_left   = 0;
    bit          steady       = 1'b0;
    int unsigned idle_cycles  = 0;

    grey_image_median u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_grey_level     (i_grey_level),
        .i_last_pixel     (i_last_pixel),
        .o_done           (o_done),
        .o_median_level   (o_median_level),
        .o_count_overflow (o_count_overflow)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // input beat: start high and busy low at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && start && busy === 1'b0)
            board.note_pixel(i_grey_level, i_last_pixel);
    end

    // result beat: o_done marks the single cycle it is valid
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            board.check_result(o_median_level, o_count_overflow);
    end

    // watchdog: no beat in either direction for too long means a hang
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one pixel beat; bursts of random length, random gaps between them
    // unless a steady stretch is running; start is held high while busy
    task automatic send_pixel(input logic [LEVEL_W-1:0] level, input logic last_pixel);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = steady ? 0 : $urandom_range(0, 12);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start        <= 1'b1;
        i_grey_level <= level;
        i_last_pixel <= last_pixel;
        do @(posedge i_clk); while (busy !== 1'b0);
        pixels_sent++;
    endtask

    task automatic send_levels(input logic [LEVEL_W-1:0] levels [$]);
        foreach (levels[i]) send_pixel(levels[i], i == levels.size() - 1);
    endtask

    function automatic logic [LEVEL_W-1:0] pick_level(t_level_mix mix,
                                                      logic [LEVEL_W-1:0] anchor);
        logic [LEVEL_W-1:0] lv;
        case (mix)
            MIX_CLUSTER:  lv = anchor + LEVEL_W'($urandom_range(0, 3));
            MIX_FLAT:     lv = anchor;
            MIX_EXTREMES: lv = $urandom_range(0, 1) ? LEVEL_MAX : '0;
            default:      lv = LEVEL_W'($urandom_range(0, LEVEL_MAX));
        endcase
        return lv;
    endfunction

    task automatic send_random_frame();
        int unsigned        len;
        int unsigned        pick;
        t_level_mix         mix;
        logic [LEVEL_W-1:0] anchor;
        pick   = $urandom_range(0, 99);
        // mostly short frames so many medians come out, a few long ones
        len    = (pick < 70) ? $urandom_range(1, 12) :
                 (pick < 95) ? $urandom_range(13, 64) : $urandom_range(65, 300);
        mix    = t_level_mix'($urandom_range(MIX_UNIFORM, MIX_EXTREMES));
        anchor = LEVEL_W'($urandom_range(0, LEVEL_MAX));
        steady = ($urandom_range(0, 3) == 0);
        for (int unsigned i = 0; i < len; i++)
            send_pixel(pick_level(mix, anchor), i == len - 1);
    endtask

    initial begin
        logic [LEVEL_W-1:0] levels [$];
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-pixel frames at both ends of the range
        levels = '{8'd0};
        send_levels(levels);
        levels = '{8'd255};
        send_levels(levels);
        // even count picks the upper median
        levels = '{8'd0, 8'd255};
        send_levels(levels);
        levels = '{8'd4, 8'd1, 8'd3, 8'd2};
        send_levels(levels);
        // odd count, unsorted input
        levels = '{8'd255, 8'd0, 8'd128};
        send_levels(levels);
        // repeated level
        levels = '{8'd7, 8'd7, 8'd7};
        send_levels(levels);
        // alternating bit patterns
        levels = '{8'h55, 8'hAA, 8'h0F, 8'hF0, 8'hAA};
        send_levels(levels);

        // random frames, overflow flag stays clear
        pixels_sent = 0;
        while (pixels_sent < PIXEL_GOAL)
            send_random_frame();

        start <= 1'b0;
        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (board.pending_q.size() != 0) begin
            $error("%0d median results never arrived", board.pending_q.size());
            board.failures++;
        end
        if (board.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
src/gim_pkg.sv
src/gim_hist_ram.sv
src/gim_median_scan.sv
src/grey_image_median.sv
sim/grey_image_median_test.sv
